### rtl/log_record_crc_parser_defines.svh
`ifndef LOG_RECORD_CRC_PARSER_DEFINES_SVH
`define LOG_RECORD_CRC_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LRCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LRCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lrcp_pkg.sv
package lrcp_pkg;

  localparam logic [7:0]  OP_PUT    = 8'h01;
  localparam logic [7:0]  OP_REMOVE = 8'h02;
  localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [1:0]  CNT_LAST  = 2'd3;

  typedef enum logic [3:0] {
    PH_OP   = 4'd0,
    PH_KLEN = 4'd1,
    PH_KEY  = 4'd2,
    PH_VLEN = 4'd3,
    PH_VAL  = 4'd4,
    PH_CRC  = 4'd5,
    PH_HALT = 4'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_KEY      = 3'd0,
    K_VAL      = 3'd1,
    K_PUT      = 3'd2,
    K_REMOVE   = 3'd3,
    K_MISMATCH = 3'd4,
    K_UNKNOWN  = 3'd5,
    K_TRUNC    = 3'd6,
    K_END      = 3'd7
  } kind_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] log_byte;
    logic       end_of_log;
  } in_item_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] payload;
  } result_t;

  typedef struct packed {
    logic halted;
  } parse_status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

### rtl/lrcp_in_reg.sv
module lrcp_in_reg import lrcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_log_byte,
  input  logic       in_end_of_log,
  input  logic       take,
  output in_item_t   item
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       eol_r;
  logic       load;

  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_log_byte;
      eol_r  <= in_end_of_log;
    end
  end

  assign item = '{valid: valid_r, log_byte: byte_r, end_of_log: eol_r};

endmodule

### rtl/lrcp_parser.sv
module lrcp_parser import lrcp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  in_item_t      item,
  input  logic          take,
  output result_t       res,
  output parse_status_t status
);

  phase_t      phase_r, phase_nxt;
  logic        is_put_r, is_put_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] exp_r, exp_nxt;

  logic [7:0]  b;
  logic [31:0] shifted;
  logic [31:0] len_acc;
  logic [31:0] exp_acc;
  logic [31:0] crc_upd;
  logic [31:0] rem_dec;

  assign b       = item.log_byte;
  assign shifted = {24'd0, b} << {cnt_r, 3'b000};
  assign len_acc = rem_r | shifted;
  assign exp_acc = exp_r | shifted;
  assign crc_upd = crc_byte(crc_r, b);
  assign rem_dec = rem_r - 32'd1;

  always_comb begin
    phase_nxt  = phase_r;
    is_put_nxt = is_put_r;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    crc_nxt    = crc_r;
    exp_nxt    = exp_r;
    res        = '{valid: 1'b0, kind: K_KEY, payload: 8'd0};
    if (phase_r != PH_HALT) begin
      if (item.end_of_log) begin
        phase_nxt = PH_HALT;
        res.valid = 1'b1;
        res.kind  = (phase_r == PH_OP) ? K_END : K_TRUNC;
      end else begin
        case (phase_r)
          PH_OP: begin
            if (b inside {OP_PUT, OP_REMOVE}) begin
              is_put_nxt = (b == OP_PUT);
              crc_nxt    = crc_byte(CRC_INIT, b);
              cnt_nxt    = 2'd0;
              rem_nxt    = 32'd0;
              phase_nxt  = PH_KLEN;
            end else begin
              phase_nxt = PH_HALT;
              res.valid = 1'b1;
              res.kind  = K_UNKNOWN;
            end
          end
          PH_KLEN, PH_VLEN: begin
            crc_nxt = crc_upd;
            rem_nxt = len_acc;
            if (cnt_r == CNT_LAST) begin
              cnt_nxt = 2'd0;
              if (len_acc == 32'd0) begin
                exp_nxt = 32'd0;
                if (phase_r == PH_KLEN && is_put_r) begin
                  phase_nxt = PH_VLEN;
                end else begin
                  phase_nxt = PH_CRC;
                end
              end else begin
                phase_nxt = (phase_r == PH_KLEN) ? PH_KEY : PH_VAL;
              end
            end else begin
              cnt_nxt = cnt_r + 2'd1;
            end
          end
          PH_KEY, PH_VAL: begin
            crc_nxt     = crc_upd;
            rem_nxt     = rem_dec;
            res.valid   = 1'b1;
            res.kind    = (phase_r == PH_KEY) ? K_KEY : K_VAL;
            res.payload = b;
            if (rem_dec == 32'd0) begin
              cnt_nxt = 2'd0;
              exp_nxt = 32'd0;
              if (phase_r == PH_KEY && is_put_r) begin
                phase_nxt = PH_VLEN;
              end else begin
                phase_nxt = PH_CRC;
              end
            end
          end
          PH_CRC: begin
            exp_nxt = exp_acc;
            if (cnt_r == CNT_LAST) begin
              cnt_nxt   = 2'd0;
              res.valid = 1'b1;
              if (~crc_r != exp_acc) begin
                phase_nxt = PH_HALT;
                res.kind  = K_MISMATCH;
              end else begin
                phase_nxt = PH_OP;
                crc_nxt   = CRC_INIT;
                rem_nxt   = 32'd0;
                res.kind  = is_put_r ? K_PUT : K_REMOVE;
              end
            end else begin
              cnt_nxt = cnt_r + 2'd1;
            end
          end
          default: begin
            phase_nxt = PH_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OP;
      is_put_r <= 1'b0;
      cnt_r    <= 2'd0;
      rem_r    <= 32'd0;
      crc_r    <= CRC_INIT;
      exp_r    <= 32'd0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      is_put_r <= is_put_nxt;
      cnt_r    <= cnt_nxt;
      rem_r    <= rem_nxt;
      crc_r    <= crc_nxt;
      exp_r    <= exp_nxt;
    end
  end

  assign status = '{halted: (phase_r == PH_HALT)};

endmodule

### rtl/log_record_crc_parser.sv
// Flow: a request accepted into the input register has its result written into
// the output register when out_stall allows, where the consumer can take it.
// Throughput: one request per cycle unless out_stall holds a result; the CRC
// byte update and length counter step lie between input and output registers.
// Reset: synchronous, active low; clears handshake state, parse phase and CRC.
`include "log_record_crc_parser_defines.svh"

module log_record_crc_parser import lrcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_log_byte,
  input  logic       in_end_of_log,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_item_kind,
  output logic [7:0] out_payload_byte
);

  in_item_t      item;
  result_t       res;
  parse_status_t status;
  logic          out_free;
  logic          take;
  logic          out_valid_r;
  logic          out_valid_nxt;
  kind_t         kind_r;
  logic [7:0]    payload_r;

  assign out_free = !out_valid_r || !out_stall;
  assign take     = item.valid && out_free;

  lrcp_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_log_byte  (in_log_byte),
    .in_end_of_log(in_end_of_log),
    .take         (take),
    .item         (item)
  );

  lrcp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .take  (take),
    .res   (res),
    .status(status)
  );

  assign out_valid_nxt = out_free ? (take && res.valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && take && res.valid) begin
      kind_r    <= res.kind;
      payload_r <= res.payload;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_item_kind    = kind_r;
  assign out_payload_byte = payload_r;

  `LRCP_ASSERT_NOW(a_payload_zero, out_valid_r && kind_r != K_KEY && kind_r != K_VAL,
                   payload_r == 8'd0, "payload set on a status result")
  `LRCP_ASSERT_NEXT(a_halt_sticky, status.halted, status.halted, "parser left halt")
  `LRCP_ASSERT_NEXT(a_result_lands, take && res.valid, out_valid_r, "result lost")

endmodule
